>>> hw/rtl/utf8_to_ascii_sanitizer_assert.svh
// Assertion macros for the UTF-8 to ASCII sanitizer.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef UTF8_TO_ASCII_SANITIZER_ASSERT_SVH
`define UTF8_TO_ASCII_SANITIZER_ASSERT_SVH
`ifndef SYNTH
// Hold prop at every rising clock edge outside reset.
`define U2A_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("u2a assertion failed");
// Flag cond whenever it is seen outside reset.
`define U2A_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("u2a forbidden condition seen");
`else
`define U2A_ASSERT(lbl, prop)
`define U2A_ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> hw/rtl/u2a_pkg.sv
// Shared types, constants and the code point folding function of the sanitizer.
// No dependencies.
`default_nettype none
package u2a_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_of_run;
  } out_t;

  // Kind of folded output: one character, "..." or "+/-".
  typedef enum logic [1:0] {
    TK_CHAR,
    TK_DOTS,
    TK_PM
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [6:0] ch;
  } tok_t;

  typedef struct packed {
    logic hit;
    tok_t tok;
  } map_t;

  localparam int unsigned CpW     = 21;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QIdxW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [6:0] ChSpace  = 7'h20;
  localparam logic [6:0] ChHyphen = 7'h2D;
  localparam logic [6:0] ChQuote  = 7'h27;
  localparam logic [6:0] ChDquote = 7'h22;
  localparam logic [6:0] ChDot    = 7'h2E;
  localparam logic [6:0] ChPlus   = 7'h2B;
  localparam logic [6:0] ChSlash  = 7'h2F;

  localparam logic [CpW-1:0] MinCp2 = 21'h00080;
  localparam logic [CpW-1:0] MinCp3 = 21'h00800;
  localparam logic [CpW-1:0] MinCp4 = 21'h10000;

  // Fold one decoded code point to its ASCII token; hit low means drop.
  function automatic map_t map_cp(logic [CpW-1:0] cp);
    map_t m;
    m.hit      = 1'b1;
    m.tok.kind = TK_CHAR;
    m.tok.ch   = cp[6:0];
    if (cp >= 21'h20 && cp <= 21'h7E) begin
      m.hit = 1'b1;
    end else begin
      case (cp) inside
        21'h09, 21'h0A, 21'h0D, 21'hA0: m.tok.ch = ChSpace;
        21'h2013, 21'h2014, 21'hB7:     m.tok.ch = ChHyphen;
        21'h2018, 21'h2019:             m.tok.ch = ChQuote;
        21'h201C, 21'h201D:             m.tok.ch = ChDquote;
        21'h2026:                       m.tok.kind = TK_DOTS;
        21'hB1:                         m.tok.kind = TK_PM;
        default:                        m.hit = 1'b0;
      endcase
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/u2a_decode.sv
// Front end: UTF-8 sequence decoder, validity checks and ASCII folding.
// Depends on u2a_pkg.
`default_nettype none
module u2a_decode (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire u2a_pkg::in_t in_i,
  output logic              tok_valid_o,
  output u2a_pkg::tok_t     tok_o
);

  logic [u2a_pkg::CpW-1:0] partial_q, partial_d;
  logic [1:0]              expect_q, expect_d;
  logic [2:0]              len_q, len_d;

  logic [u2a_pkg::CpW-1:0] cp_cont;
  logic [1:0]              expect_dec;
  logic                    is_cont, fresh, ok;
  u2a_pkg::map_t           m_cont, m_byte, m_sel;
  logic [7:0]              b;

  assign b          = in_i.in_byte;
  assign is_cont    = (b[7:6] == 2'b10);
  assign cp_cont    = {partial_q[u2a_pkg::CpW-7:0], b[5:0]};
  assign expect_dec = expect_q - 2'd1;
  assign m_cont     = u2a_pkg::map_cp(cp_cont);
  assign m_byte     = u2a_pkg::map_cp({{(u2a_pkg::CpW-8){1'b0}}, b});

  always_comb begin
    ok = 1'b1;
    if (len_q == 3'd2 && cp_cont < u2a_pkg::MinCp2) ok = 1'b0;
    if (len_q == 3'd3 && cp_cont < u2a_pkg::MinCp3) ok = 1'b0;
    if (len_q == 3'd4 && cp_cont < u2a_pkg::MinCp4) ok = 1'b0;
  end

  always_comb begin
    partial_d = partial_q;
    expect_d  = expect_q;
    len_d     = len_q;
    fresh     = 1'b1;
    m_sel     = '0;
    if (expect_q != 2'd0) begin
      if (is_cont) begin
        fresh     = 1'b0;
        partial_d = cp_cont;
        expect_d  = expect_dec;
        if (expect_dec == 2'd0) begin
          partial_d = '0;
          len_d     = '0;
          if (ok) m_sel = m_cont;
        end
      end else begin
        // Drop the unfinished sequence and treat this byte as new.
        partial_d = '0;
        expect_d  = '0;
        len_d     = '0;
      end
    end
    if (fresh) begin
      if (!b[7]) begin
        m_sel = m_byte;
      end else if (b[7:5] == 3'b110) begin
        partial_d = {{(u2a_pkg::CpW-5){1'b0}}, b[4:0]};
        expect_d  = 2'd1;
        len_d     = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        partial_d = {{(u2a_pkg::CpW-4){1'b0}}, b[3:0]};
        expect_d  = 2'd2;
        len_d     = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        partial_d = {{(u2a_pkg::CpW-3){1'b0}}, b[2:0]};
        expect_d  = 2'd3;
        len_d     = 3'd4;
      end
    end
    if (in_i.end_of_text) begin
      partial_d = '0;
      expect_d  = '0;
      len_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      expect_q  <= '0;
      len_q     <= '0;
    end else if (accept_i) begin
      partial_q <= partial_d;
      expect_q  <= expect_d;
      len_q     <= len_d;
    end
  end

  assign tok_valid_o = accept_i && m_sel.hit;
  assign tok_o       = m_sel.tok;

endmodule
`default_nettype wire

>>> hw/rtl/u2a_fifo.sv
// Short token queue between the decoder and the expander.
// Depends on u2a_pkg.
`default_nettype none
module u2a_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire u2a_pkg::tok_t wdata_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output u2a_pkg::tok_t      rdata_o
);

  u2a_pkg::tok_t                mem_q [u2a_pkg::QDepth];
  logic [u2a_pkg::QIdxW-1:0]    wr_q, rd_q;
  logic [u2a_pkg::QCntW-1:0]    cnt_q;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == u2a_pkg::QCntW'(u2a_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + u2a_pkg::QCntW'(do_push) - u2a_pkg::QCntW'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/u2a_expand.sv
// Back end: expands queued tokens into output characters, held in an output register.
// Depends on u2a_pkg and the assertion macro header.
`default_nettype none
`include "utf8_to_ascii_sanitizer_assert.svh"
module u2a_expand (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire u2a_pkg::tok_t q_data_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output u2a_pkg::out_t      out_o
);

  u2a_pkg::tok_t cur_q;
  logic [1:0]    idx_q;
  logic          vld_q;
  logic          last, take;

  assign last    = (cur_q.kind == u2a_pkg::TK_CHAR) || (idx_q == 2'd2);
  assign take    = !vld_q || (pop_i && last);
  assign q_pop_o = take && !q_empty_i;
  assign empty_o = !vld_q;

  always_comb begin
    out_o.last_of_run = last;
    unique case (cur_q.kind)
      u2a_pkg::TK_CHAR: out_o.out_char = cur_q.ch;
      u2a_pkg::TK_DOTS: out_o.out_char = u2a_pkg::ChDot;
      u2a_pkg::TK_PM: begin
        case (idx_q)
          2'd0:    out_o.out_char = u2a_pkg::ChPlus;
          2'd1:    out_o.out_char = u2a_pkg::ChSlash;
          default: out_o.out_char = u2a_pkg::ChHyphen;
        endcase
      end
      default: out_o.out_char = u2a_pkg::ChSpace;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (take) begin
      vld_q <= !q_empty_i;
      idx_q <= '0;
    end else if (pop_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  `U2A_ASSERT(a_hold_mid_run, vld_q && pop_i && !last |=> vld_q && $stable(cur_q))
  `U2A_ASSERT(a_printable, vld_q |-> out_o.out_char >= 7'h20 && out_o.out_char <= 7'h7E)
  `U2A_ASSERT_NEVER(a_single_idx, vld_q && cur_q.kind == u2a_pkg::TK_CHAR && idx_q != 2'd0)
  `U2A_ASSERT_NEVER(a_pop_while_busy, q_pop_o && vld_q && !(pop_i && last))

endmodule
`default_nettype wire

>>> hw/rtl/utf8_to_ascii_sanitizer.sv
// UTF-8 to printable ASCII sanitizer, top level.
// Depends on u2a_pkg, u2a_decode, u2a_fifo and u2a_expand.
//
// Usage:
//   Input side is a queue write port: present in_data_i and raise push_i; the
//   byte transaction is taken at a clock edge where push_i is high and full
//   is low. One byte may be taken every cycle.
//   Output side is a queue read port: while empty is low, out_data_o holds
//   the oldest character; raise pop_i to take it. last_of_run marks the final
//   character produced by one input byte.
// Path: a byte that completes a code point shows its first character on the
//   output once its token has passed from the decoder through the token queue
//   into the output register.
// Throughput: one byte per cycle in while full is low; one character per cycle
//   out while pop_i is high. An ellipsis or plus-minus gives three characters;
//   the four-entry token queue soaks up these bursts; full means it is full.
// Stall: a receiver that holds pop_i low freezes the output register; the
//   queue then fills and full back-pressures the sender. Nothing is lost.
// Reset: rst_ni low clears decode state and empties the queue and the output
//   register; no clearing pass is needed, the block takes bytes straight after reset.
`default_nettype none
module utf8_to_ascii_sanitizer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full,
  input  wire u2a_pkg::in_t  in_data_i,
  output logic               empty,
  input  wire logic          pop_i,
  output u2a_pkg::out_t      out_data_o
);

  logic          accept;
  logic          tok_valid;
  u2a_pkg::tok_t tok;
  logic          q_full, q_empty, q_pop;
  u2a_pkg::tok_t q_data;

  // Hold the sender off whenever the token queue has no room.
  assign full   = q_full;
  assign accept = push_i && !q_full;

  u2a_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_data_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok)
  );

  u2a_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_valid),
    .wdata_i (tok),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  u2a_expand u_expand (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop_i),
    .out_o     (out_data_o)
  );

endmodule
`default_nettype wire

>>> tb/utf8_to_ascii_sanitizer_test.sv
// Self-checking testbench for utf8_to_ascii_sanitizer: byte transactions in, ASCII out.
// Depends on u2a_pkg for the in_t and out_t payload types and on the RTL of the block.
`default_nettype none
module utf8_to_ascii_sanitizer_test;

  localparam int QuietLimit   = 2000; // cycles with no transaction before giving up
  localparam int StallCycles  = 300;  // long receiver hold-off, fills the block
  localparam int PauseCycles  = 20;   // sender pause once everything has drained
  localparam int SettleCycles = 10;   // extra cycles after the last character
  localparam int PhaseBytes   = 110;
  localparam int MaxReports   = 50;

  logic           clk_i      = 1'b0;
  logic           rst_ni     = 1'b0;
  logic           push_i     = 1'b0;
  logic           pop_i      = 1'b0;
  u2a_pkg::in_t   in_data_i  = '0;
  logic           full;
  logic           empty;
  u2a_pkg::out_t  out_data_o;

  utf8_to_ascii_sanitizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop_i      (pop_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Bytes waiting to be offered, and the characters the block still owes us.
  u2a_pkg::in_t  bytes_pending[$];
  u2a_pkg::out_t ascii_due[$];

  int   bytes_queued  = 0;
  int   bytes_taken   = 0;
  int   mismatches    = 0;
  int   quiet_cycles  = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   stall_req_id  = 0;
  int   stall_ack_id  = 0;
  int   stall_left    = 0;
  logic byte_taken    = 1'b0;

  // Decoder state as the block should hold it.
  logic [20:0] cp_acc    = '0;
  logic [1:0]  cont_left = '0;
  logic [2:0]  seq_len   = '0;

  task automatic report_mismatch(string what);
    if (mismatches < MaxReports) $display("mismatch: %s", what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Fold one decoded code point to the ASCII text it stands for; empty means drop.
  function automatic string fold_cp(logic [20:0] cp);
    if (cp >= 21'hD800 && cp <= 21'hDFFF) return "";
    if (cp >= 21'h20 && cp <= 21'h7E) return $sformatf("%c", cp[7:0]);
    case (cp)
      21'h09, 21'h0A, 21'h0D, 21'hA0: return " ";
      21'h2013, 21'h2014, 21'hB7:     return "-";
      21'h2018, 21'h2019:             return "'";
      21'h201C, 21'h201D:             return "\"";
      21'h2026:                       return "...";
      21'hB1:                         return "+/-";
      default:                        return "";
    endcase
  endfunction

  function automatic void clear_sequence();
    cp_acc    = '0;
    cont_left = '0;
    seq_len   = '0;
  endfunction

  // Advance the decoder by one accepted byte and queue the characters it yields.
  function automatic void predict_byte(u2a_pkg::in_t item);
    logic [7:0]    b;
    string         text;
    logic          fresh;
    u2a_pkg::out_t res;
    b     = item.in_byte;
    text  = "";
    fresh = 1'b1;
    if (cont_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        fresh     = 1'b0;
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          // reject overlong forms before folding
          if (!(seq_len == 3'd2 && cp_acc < 21'h80) &&
              !(seq_len == 3'd3 && cp_acc < 21'h800) &&
              !(seq_len == 3'd4 && cp_acc < 21'h10000)) begin
            text = fold_cp(cp_acc);
          end
          clear_sequence();
        end
      end else begin
        // a non-continuation byte drops the pending lead and starts afresh
        clear_sequence();
      end
    end
    if (fresh) begin
      if (!b[7]) begin
        text = fold_cp({13'd0, b});
      end else if (b[7:5] == 3'b110) begin
        cp_acc = {16'd0, b[4:0]}; cont_left = 2'd1; seq_len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc = {17'd0, b[3:0]}; cont_left = 2'd2; seq_len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc = {18'd0, b[2:0]}; cont_left = 2'd3; seq_len = 3'd4;
      end
    end
    if (item.end_of_text) clear_sequence();
    for (int i = 0; i < text.len(); i++) begin
      res.out_char    = 7'(text[i]);
      res.last_of_run = (i == text.len() - 1);
      ascii_due.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic void queue_byte(logic [7:0] b, logic eot = 1'b0);
    u2a_pkg::in_t item;
    item.in_byte     = b;
    item.end_of_text = eot;
    bytes_pending.push_back(item);
    bytes_queued++;
  endfunction

  // Encode cp in len bytes; a longer len than needed gives an overlong form.
  function automatic void queue_cp(logic [20:0] cp, int len, logic eot = 1'b0);
    case (len)
      1: queue_byte(cp[7:0], eot);
      2: begin
        queue_byte({3'b110, cp[10:6]});
        queue_byte({2'b10, cp[5:0]}, eot);
      end
      3: begin
        queue_byte({4'b1110, cp[15:12]});
        queue_byte({2'b10, cp[11:6]});
        queue_byte({2'b10, cp[5:0]}, eot);
      end
      default: begin
        queue_byte({5'b11110, cp[20:18]});
        queue_byte({2'b10, cp[17:12]});
        queue_byte({2'b10, cp[11:6]});
        queue_byte({2'b10, cp[5:0]}, eot);
      end
    endcase
  endfunction

  function automatic int shortest_len(logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Mostly well-formed text with random content; the rest is broken on purpose.
  function automatic void queue_random_text(int n_bytes);
    logic [20:0] folded[13] = '{21'h09, 21'h0A, 21'h0D, 21'hA0, 21'h2013, 21'h2014,
                                21'hB7, 21'h2018, 21'h2019, 21'h201C, 21'h201D,
                                21'h2026, 21'hB1};
    int          stop_at;
    int          kind;
    int          len;
    logic        eot;
    logic [20:0] cp;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      kind = $urandom_range(99);
      eot  = ($urandom_range(11) == 0);
      if (kind < 35) begin
        queue_byte(8'($urandom_range(8'h20, 8'h7E)), eot);
      end else if (kind < 43) begin
        // control characters, DEL among them
        queue_byte((kind < 40) ? 8'($urandom_range(0, 31)) : 8'h7F, eot);
      end else if (kind < 68) begin
        cp = folded[$urandom_range(12)];
        queue_cp(cp, shortest_len(cp), eot);
      end else if (kind < 80) begin
        // any code point in a 2..4 byte frame: overlongs, surrogates, out of range
        len = $urandom_range(2, 4);
        cp  = 21'($urandom) & ((21'd1 << (len == 2 ? 11 : len == 3 ? 16 : 21)) - 21'd1);
        queue_cp(cp, len, eot);
      end else if (kind < 88) begin
        // truncated sequence: lead and too few continuations, then ASCII
        len = $urandom_range(2, 4);
        cp  = 21'($urandom);
        case (len)
          2:       queue_byte({3'b110, cp[4:0]}, eot);
          3:       queue_byte({4'b1110, cp[3:0]}, eot && cp[8]);
          default: queue_byte({5'b11110, cp[2:0]}, eot && cp[8]);
        endcase
        for (int i = 0; i < $urandom_range(0, len - 2); i++) begin
          queue_byte({2'b10, 6'($urandom)}, eot && (i == 0));
        end
        queue_byte(8'($urandom_range(8'h00, 8'h7F)));
      end else if (kind < 94) begin
        queue_byte(8'($urandom_range(8'h80, 8'hBF)), eot);
      end else begin
        queue_byte(8'($urandom_range(8'hF8, 8'hFF)), eot);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: sample the input transaction at the rising edge, drive at the falling
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    byte_taken <= rst_ni && push_i && !full;
    if (rst_ni && push_i && !full) begin
      bytes_taken++;
      predict_byte(in_data_i);
    end
  end

  always @(negedge clk_i) begin
    if (push_i && !byte_taken) begin
      // hold the offered byte until the block takes it
    end else if (bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      push_i    <= 1'b1;
      in_data_i <= bytes_pending.pop_front();
    end else begin
      push_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random pop, with a long hold-off when asked for one
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (stall_req_id != stall_ack_id) begin
      stall_ack_id <= stall_req_id;
      stall_left   <= StallCycles;
      pop_i        <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop_i      <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each output transaction with the oldest expected character
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    u2a_pkg::out_t due;
    if (rst_ni) begin
      if (pop_i && !empty) begin
        if (ascii_due.size() == 0) begin
          report_mismatch($sformatf("unexpected character %02h last %0b",
                                    out_data_o.out_char, out_data_o.last_of_run));
        end else begin
          due = ascii_due.pop_front();
          if (out_data_o.out_char !== due.out_char)
            report_mismatch($sformatf("out_char %02h, want %02h",
                                      out_data_o.out_char, due.out_char));
          if (out_data_o.last_of_run !== due.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, want %0b on char %02h",
                                      out_data_o.last_of_run, due.last_of_run,
                                      due.out_char));
        end
      end
      // watchdog: any transaction on either side counts as progress
      if ((push_i && !full) || (pop_i && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("timeout: no transaction for %0d cycles", QuietLimit);
          $display("FAIL utf8_to_ascii_sanitizer");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Hold until every queued byte is taken and every expected character is out.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || ascii_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 15;
    recv_idle_pct = 67;

    // Directed text: extremes, the space, dash, ellipsis and plus-minus foldings and each malformed shape.
    queue_byte(8'h41);
    queue_byte(8'h7E);
    queue_byte(8'h7F);                           // DEL, dropped
    queue_byte(8'h09);                           // tab folds to space
    queue_cp(21'hA0, 2);                         // no-break space
    queue_cp(21'h2026, 3);                       // ellipsis, three characters
    queue_cp(21'hB1, 2);                         // plus-minus, three characters
    queue_byte(8'h80);                           // stray continuation
    queue_byte(8'hFF);                           // never valid in UTF-8
    queue_byte(8'hC1);                           // overlong DEL
    queue_byte(8'hBF);
    queue_cp(21'hD800, 3);                       // surrogate
    queue_byte(8'hE2);                           // truncated lead, then ASCII afresh
    queue_byte(8'h78);
    queue_cp(21'h110000, 4);                     // beyond the code space
    queue_byte(8'hC2, 1'b1);                     // lead at end of text, discarded
    queue_byte(8'hA0);                           // so this is stray
    queue_cp(21'h2014, 3, 1'b1);                 // em dash closing a string
    wait_drained();

    queue_random_text(PhaseBytes);
    wait_drained();
    repeat (PauseCycles) @(negedge clk_i);

    // Other way round: sender idles heavily, receiver lightly.
    send_idle_pct = 67;
    recv_idle_pct = 15;
    queue_random_text(PhaseBytes);
    wait_drained();
    repeat (PauseCycles) @(negedge clk_i);

    // No idling; the receiver holds off first so the block fills and stalls input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req_id++;
    queue_random_text(PhaseBytes);
    wait_drained();

    repeat (SettleCycles) @(negedge clk_i);
    if (ascii_due.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", ascii_due.size()));
    if (mismatches == 0) begin
      $display("PASS utf8_to_ascii_sanitizer");
    end else begin
      $display("FAIL utf8_to_ascii_sanitizer");
    end
    $finish;
  end

endmodule
`default_nettype wire
